FILE: hw/rtl/sfa_pkg.sv
package sfa_pkg;

    // Channel and field widths
    localparam int MAX_CHANNELS = 8;
    localparam int SAMPLE_W     = 32;
    localparam int STAMP_W      = 64;
    localparam int HEADER_W     = 32;
    localparam int NUM_W        = 32;
    localparam int FRAME_W      = 16;
    localparam int WRAP_W       = 31;

    // APB register map: register i at byte address 4*i
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;
    localparam int REG_SEL_BIT  = 2;

    // Register reset values
    localparam logic [FRAME_W-1:0] PPF_RESET  = FRAME_W'(16);
    localparam logic [WRAP_W-1:0]  WRAP_RESET = '0;

    // Header bit 0 carries frame sync; the packet number sits above it
    localparam int FRAME_SYNC_BITS = 1;

    typedef enum logic [0:0] {
        REG_FRAME_SIZE    = 1'b0,
        REG_SEQUENCE_WRAP = 1'b1
    } reg_idx_t;

    typedef logic [SAMPLE_W-1:0]          word_t;
    typedef word_t [MAX_CHANNELS-1:0]     word_vec_t;

    // Per-packet decision from the sequence checker
    typedef struct packed {
        logic accum;
        logic frame_done;
        logic seq_error;
    } seq_ctrl_t;

    // One result transfer
    typedef struct packed {
        logic               seq_error;
        logic [STAMP_W-1:0] stamp;
        word_vec_t          totals;
    } result_t;

endpackage

FILE: hw/rtl/sfa_seq.sv
module sfa_seq
    import sfa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_accept,
    input  logic [HEADER_W-1:0] header_word,
    input  logic [FRAME_W-1:0]  frame_size,
    input  logic [WRAP_W-1:0]   sequence_wrap,
    output seq_ctrl_t           ctrl
);

    logic [NUM_W-1:0]   prev_reg, prev_next;
    logic [FRAME_W-1:0] pif_reg, pif_next;
    logic               halted_reg, halted_next;

    logic [NUM_W-1:0]   number;
    logic [NUM_W-1:0]   expected;
    logic [NUM_W-1:0]   wrap_last;
    logic [FRAME_W-1:0] pif_inc;
    logic [FRAME_W-1:0] frame_len;
    logic               match;

    // Check the packet number and count packets in the frame
    always_comb begin
        number    = NUM_W'(header_word >> FRAME_SYNC_BITS);
        expected  = prev_reg + NUM_W'(1);
        wrap_last = NUM_W'(sequence_wrap) - NUM_W'(1);
        match     = (number == expected);
        pif_inc   = pif_reg + FRAME_W'(1);
        frame_len = (frame_size == '0) ? FRAME_W'(1) : frame_size;

        ctrl.accum      = s_accept && !halted_reg && match;
        ctrl.seq_error  = s_accept && !halted_reg && !match;
        ctrl.frame_done = ctrl.accum && !(pif_inc < frame_len);

        prev_next   = prev_reg;
        pif_next    = pif_reg;
        halted_next = halted_reg;

        if (ctrl.accum) begin
            // restart numbering after the last number of the wrap range
            prev_next = (number == wrap_last) ? '1 : number;
            pif_next  = ctrl.frame_done ? '0 : pif_inc;
        end
        if (ctrl.seq_error) begin
            halted_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg   <= '1;
            pif_reg    <= '0;
            halted_reg <= 1'b0;
        end else begin
            prev_reg   <= prev_next;
            pif_reg    <= pif_next;
            halted_reg <= halted_next;
        end
    end

endmodule

FILE: hw/rtl/sfa_lane.sv
module sfa_lane
    import sfa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  seq_ctrl_t ctrl,
    input  word_t     sample,
    output word_t     total
);

    word_t sum_reg, sum_next;

    // Add the sample; the result carries the sum including this packet
    assign total = sum_reg + sample;

    always_comb begin
        sum_next = sum_reg;
        if (ctrl.accum) begin
            sum_next = ctrl.frame_done ? '0 : total;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else begin
            sum_reg <= sum_next;
        end
    end

endmodule

FILE: hw/rtl/sfa_merge.sv
module sfa_merge
    import sfa_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  seq_ctrl_t          ctrl,
    input  logic [STAMP_W-1:0] stamp_in,
    input  word_vec_t          totals,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output result_t            m_result
);

    result_t     slot0_reg, slot0_next;
    result_t     slot1_reg, slot1_next;
    logic [1:0]  count_reg, count_next;

    result_t     res;
    logic        push;
    logic        pop;

    // Build the result: a sequence break reports zeros
    always_comb begin
        res.seq_error = ctrl.seq_error;
        res.stamp     = ctrl.seq_error ? '0 : stamp_in;
        res.totals    = ctrl.seq_error ? '0 : totals;
    end

    assign push     = ctrl.frame_done || ctrl.seq_error;
    assign m_valid  = (count_reg != 2'd0);
    assign pop      = m_valid && m_ready;
    assign s_ready  = (count_reg != 2'd2);
    assign m_result = slot0_reg;

    // Two-entry result buffer: hold while the receiver stalls
    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        case ({push, pop})
            2'b10: begin
                if (count_reg == 2'd0) begin
                    slot0_next = res;
                end else begin
                    slot1_next = res;
                end
                count_next = count_reg + 2'd1;
            end
            2'b01: begin
                slot0_next = slot1_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11: begin
                if (count_reg == 2'd1) begin
                    slot0_next = res;
                end else begin
                    slot0_next = slot1_reg;
                    slot1_next = res;
                end
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

FILE: hw/rtl/packet_sequence_frame_accumulator.sv
// Packet sequence checker and frame accumulator.
// Input channel (s_*): one packet per transfer, a header word whose bits 31..1
// give the packet number, eight 32-bit channel samples and a 64-bit timestamp.
// Packet numbers must rise by one from 0; numbering restarts at 0 after
// sequence_wrap packets (zero: never). Output channel (m_*): one result per
// completed frame, whose length in packets the frame size register sets (0 acts
// as 1): the eight channel sums modulo 2^32 and the timestamp of the last
// packet. A sequence break gives one result with m_sequence_error high and
// zeros elsewhere, then every later packet is taken and dropped until reset.
// Throughput: one packet per cycle while s_ready is high; one adder per channel
// lane and the number compare all close in the accepting cycle. The result of
// the transfer that completes a frame is registered and shows on m_* after any
// earlier results. A two-entry result buffer lets packets keep flowing while
// the receiver stalls; s_ready drops only while two results wait.
// Reset (aresetn, synchronous, active low): sums clear, next expected number
// is 0, registers return to a frame size of 16 and sequence_wrap = 0.
// APB: frame size at 0x0, sequence_wrap at 0x4; write only while idle.
module packet_sequence_frame_accumulator
    import sfa_pkg::*;
#(
    parameter int CHANNELS = MAX_CHANNELS
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [HEADER_W-1:0]   s_header_word,
    input  logic [SAMPLE_W-1:0]   s_sample_0,
    input  logic [SAMPLE_W-1:0]   s_sample_1,
    input  logic [SAMPLE_W-1:0]   s_sample_2,
    input  logic [SAMPLE_W-1:0]   s_sample_3,
    input  logic [SAMPLE_W-1:0]   s_sample_4,
    input  logic [SAMPLE_W-1:0]   s_sample_5,
    input  logic [SAMPLE_W-1:0]   s_sample_6,
    input  logic [SAMPLE_W-1:0]   s_sample_7,
    input  logic [STAMP_W-1:0]    s_stamp_in,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_sequence_error,
    output logic [STAMP_W-1:0]    m_stamp_out,
    output logic [SAMPLE_W-1:0]   m_total_0,
    output logic [SAMPLE_W-1:0]   m_total_1,
    output logic [SAMPLE_W-1:0]   m_total_2,
    output logic [SAMPLE_W-1:0]   m_total_3,
    output logic [SAMPLE_W-1:0]   m_total_4,
    output logic [SAMPLE_W-1:0]   m_total_5,
    output logic [SAMPLE_W-1:0]   m_total_6,
    output logic [SAMPLE_W-1:0]   m_total_7
);

    logic [FRAME_W-1:0] ppf_reg, ppf_next;
    logic [WRAP_W-1:0]  wrap_reg, wrap_next;
    logic               cfg_wr;
    reg_idx_t           reg_sel;

    logic               s_accept;
    seq_ctrl_t          ctrl;
    word_vec_t          samples;
    word_vec_t          totals;
    result_t            m_result;

    // Configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = reg_idx_t'(paddr[REG_SEL_BIT]);

    always_comb begin
        ppf_next  = ppf_reg;
        wrap_next = wrap_reg;
        prdata    = '0;
        case (reg_sel)
            REG_FRAME_SIZE: begin
                prdata = APB_DATA_W'(ppf_reg);
                if (cfg_wr) begin
                    ppf_next = pwdata[FRAME_W-1:0];
                end
            end
            REG_SEQUENCE_WRAP: begin
                prdata = APB_DATA_W'(wrap_reg);
                if (cfg_wr) begin
                    wrap_next = pwdata[WRAP_W-1:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ppf_reg  <= PPF_RESET;
            wrap_reg <= WRAP_RESET;
        end else begin
            ppf_reg  <= ppf_next;
            wrap_reg <= wrap_next;
        end
    end

    assign s_accept = s_valid && s_ready;

    // Sequence check and frame count
    sfa_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_accept      (s_accept),
        .header_word   (s_header_word),
        .frame_size    (ppf_reg),
        .sequence_wrap (wrap_reg),
        .ctrl          (ctrl)
    );

    assign samples[0] = s_sample_0;
    assign samples[1] = s_sample_1;
    assign samples[2] = s_sample_2;
    assign samples[3] = s_sample_3;
    assign samples[4] = s_sample_4;
    assign samples[5] = s_sample_5;
    assign samples[6] = s_sample_6;
    assign samples[7] = s_sample_7;

    // One accumulator lane per channel; unused channels report zero
    for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_lane
        if (i < CHANNELS) begin : g_used
            sfa_lane u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (ctrl),
                .sample  (samples[i]),
                .total   (totals[i])
            );
        end else begin : g_unused
            assign totals[i] = '0;
        end
    end

    // Merge lane totals into the result and buffer it
    sfa_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .stamp_in (s_stamp_in),
        .totals   (totals),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_sequence_error = m_result.seq_error;
    assign m_stamp_out      = m_result.stamp;
    assign m_total_0        = m_result.totals[0];
    assign m_total_1        = m_result.totals[1];
    assign m_total_2        = m_result.totals[2];
    assign m_total_3        = m_result.totals[3];
    assign m_total_4        = m_result.totals[4];
    assign m_total_5        = m_result.totals[5];
    assign m_total_6        = m_result.totals[6];
    assign m_total_7        = m_result.totals[7];

endmodule
